/* design/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// shared constants, opcodes and sideband types for the text console engine
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int DEF_MAX_COLUMNS   = 128;
    localparam int DEF_MAX_ROWS      = 64;
    localparam int DEF_HISTORY_LINES = 256;

    localparam logic [15:0] BLANK_CELL = 16'h0020;
    localparam logic [7:0]  PUT_ATTR   = 8'h0F;
    localparam logic [8:0]  VIEW_STEP  = 9'd3;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_CURS  = 3'd3,
        OP_CLEAR = 3'd4,
        OP_VUP   = 3'd5,
        OP_VDN   = 3'd6,
        OP_VREAD = 3'd7
    } opcode_t;

    localparam logic [2:0] REG_COLS  = 3'd0;
    localparam logic [2:0] REG_ROWS  = 3'd1;
    localparam logic [2:0] REG_REN   = 3'd2;
    localparam logic [2:0] REG_LEFT  = 3'd3;
    localparam logic [2:0] REG_TOP   = 3'd4;
    localparam logic [2:0] REG_WIDTH = 3'd5;
    localparam logic [2:0] REG_HGT   = 3'd6;

    // clearing pass status handed from the sweeper to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } clr_stat_t;

endpackage

/* design/tcce_ram.sv */
// ----------------------------------------------------------------------------
// tcce_ram
// generic single-port synchronous ram, one write or read a cycle, registered read
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/tcce_sweep.sv */
// ----------------------------------------------------------------------------
// tcce_sweep
// address counter for the clearing pass over cell and history memories
// ----------------------------------------------------------------------------
module tcce_sweep #(
    parameter int AW = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic [AW-1:0]           addr,
    output tcce_pkg::clr_stat_t     stat
);
    import tcce_pkg::*;

    logic [AW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    // sweep every address once, starting after reset or on request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign addr      = cnt_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTH
    // a finished pass drops busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.busy)
        else $error("sweep done while busy");
    // counter moves only while sweeping
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !start) |=> $stable(cnt_reg))
        else $error("sweep counter moved while idle");
    // done follows the last address
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (cnt_reg == '0))
        else $error("sweep done at wrong address");
`endif

endmodule

/* design/text_console_cell_engine_unit.sv */
// A put character that scrolls copies the top window row into the history ring, moves the
//   other window rows up one row and blanks the bottom window row; a tab is put as four
//   spaces, each with its own scrolls.
// One request at a time; the next request is taken only once the result has been accepted.
// Reset and clear: a clearing pass over max(MAX_ROWS,HISTORY_LINES)*MAX_COLUMNS addresses (32768)
//   blanks both memories, and a clear's result follows the pass; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// text_console_cell_engine_unit
// text console with cell memory, cursor, scrollback ring and view window
// ----------------------------------------------------------------------------
module text_console_cell_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attribute,
    input  logic [6:0]  cell_column,
    input  logic [5:0]  cell_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cell_value,
    output logic [6:0]  cursor_column,
    output logic [5:0]  cursor_row,
    output logic [8:0]  view_offset
);
    import tcce_pkg::*;

    // geometry fixed by the package, field widths below are sized for it
    localparam int MAX_COLUMNS   = DEF_MAX_COLUMNS;
    localparam int MAX_ROWS      = DEF_MAX_ROWS;
    localparam int HISTORY_LINES = DEF_HISTORY_LINES;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int HW  = $clog2(HISTORY_LINES);
    localparam int CAW = RW + CW;
    localparam int HAW = HW + CW;
    localparam int SAW = (CAW > HAW) ? CAW : HAW;
    localparam int CCAP = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
    localparam int RCAP = (MAX_ROWS < 64) ? MAX_ROWS : 64;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RDWAIT, S_PUT, S_HRD, S_HWR,
        S_MRD, S_MWR, S_BLK, S_RES, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [7:0] cols_cfg_reg;
    logic [6:0] rows_cfg_reg;
    logic       ren_reg;
    logic [6:0] rleft_reg;
    logic [5:0] rtop_reg;
    logic [7:0] rwid_reg;
    logic [6:0] rhgt_reg;

    // request and architectural state
    logic [2:0] op_reg;
    logic [7:0] ch_reg;
    logic [7:0] at_reg;
    logic [6:0] col_reg;
    logic [5:0] row_reg;
    logic [2:0] tab_reg;
    logic [7:0] ccol_reg;
    logic [6:0] cline_reg;
    logic [HW-1:0] head_reg;
    logic [8:0] fill_reg;
    logic [8:0] back_reg;
    logic [7:0] sc_reg;
    logic [6:0] sr_reg;
    logic [15:0] val_reg;
    logic        vhist_reg;
    logic        vblank_reg;
    logic        clr_req_reg;

    // effective geometry
    logic [7:0] ecols;
    logic [6:0] erows;
    logic       rdy;
    logic       reg_ok;
    logic [7:0] wl, wr, ww;
    logic [6:0] wt, wb, wh;

    always_comb
    begin
        ecols = (cols_cfg_reg > 8'(CCAP)) ? 8'(CCAP) : cols_cfg_reg;
        erows = (rows_cfg_reg > 7'(RCAP)) ? 7'(RCAP) : rows_cfg_reg;
        rdy   = (ecols != '0) && (erows != '0);
        reg_ok = ren_reg && ({1'b0, rleft_reg} < ecols) && ({1'b0, rtop_reg} < erows)
                 && (rwid_reg != '0) && (rhgt_reg != '0);
        ww = (rwid_reg > ecols - {1'b0, rleft_reg}) ? ecols - {1'b0, rleft_reg} : rwid_reg;
        wh = (rhgt_reg > erows - {1'b0, rtop_reg}) ? erows - {1'b0, rtop_reg} : rhgt_reg;
        if (reg_ok)
        begin
            wl = {1'b0, rleft_reg};
            wr = {1'b0, rleft_reg} + ww;
            wt = {1'b0, rtop_reg};
            wb = {1'b0, rtop_reg} + wh;
        end
        else
        begin
            wl = '0;
            wr = ecols;
            wt = '0;
            wb = erows;
        end
    end

    // memories and sweep
    logic           c_we, h_we;
    logic [CAW-1:0] c_addr;
    logic [HAW-1:0] h_addr;
    logic [15:0]    c_wd, h_wd, c_rd, h_rd;
    logic [SAW-1:0] sw_addr;
    clr_stat_t      sw_stat;

    tcce_sweep #(.AW(SAW)) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (clr_req_reg),
        .addr  (sw_addr),
        .stat  (sw_stat)
    );

    tcce_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_cells (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd)
    );

    tcce_ram #(.WIDTH(16), .DEPTH(HISTORY_LINES * MAX_COLUMNS)) u_hist (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd)
    );

    // put-character decode
    logic       is_tab, is_prn, do_store;
    logic [7:0] pc;
    logic [7:0] pcol;
    logic [6:0] pline;
    logic [15:0] pval;

    always_comb
    begin
        is_tab   = (ch_reg == CH_TAB);
        pc       = is_tab ? CH_SPACE : ch_reg;
        is_prn   = (pc >= CH_SPACE) && (pc < CH_DEL);
        pcol     = ccol_reg;
        pline    = cline_reg;
        do_store = 1'b0;
        pval     = {PUT_ATTR, pc};
        if (pc == CH_NL)
        begin
            pcol  = wl;
            pline = cline_reg + 7'd1;
        end
        else if (pc == CH_CR)
        begin
            pcol = '0;
        end
        else if (pc == CH_BS)
        begin
            if (ccol_reg != '0)
            begin
                pcol = ccol_reg - 8'd1;
            end
            do_store = 1'b1;
            pval     = {PUT_ATTR, CH_SPACE};
        end
        else if (is_prn)
        begin
            do_store = 1'b1;
            pcol     = ccol_reg + 8'd1;
            if (pcol >= wr)
            begin
                pcol  = wl;
                pline = cline_reg + 7'd1;
            end
        end
        if (do_store && !((pc == CH_BS ? pcol : ccol_reg) < ecols && cline_reg < erows))
        begin
            do_store = 1'b0;
        end
    end

    // view address
    logic [6:0] hrows;
    logic [8:0] vback;
    logic [HW-1:0] vidx;
    always_comb
    begin
        hrows = (back_reg < {2'b0, erows}) ? back_reg[6:0] : erows;
        vback = back_reg - {3'b0, row_reg};
        vidx  = head_reg - vback[HW-1:0];
    end

    // memory port control
    logic [7:0] bs_col;
    assign bs_col = (pc == CH_BS) ? pcol : ccol_reg;

    always_comb
    begin
        c_we   = 1'b0;
        h_we   = 1'b0;
        c_addr = {row_reg[RW-1:0], col_reg[CW-1:0]};
        h_addr = {vidx, col_reg[CW-1:0]};
        c_wd   = {at_reg, ch_reg};
        h_wd   = c_rd;
        case (state_reg)
            S_CLR:
            begin
                c_we   = sw_stat.busy;
                h_we   = sw_stat.busy;
                c_addr = sw_addr[CAW-1:0];
                h_addr = sw_addr[HAW-1:0];
                c_wd   = BLANK_CELL;
                h_wd   = BLANK_CELL;
            end
            S_DEC:
            begin
                if (op_reg == OP_WRITE)
                begin
                    c_we = rdy && ({1'b0, col_reg} < ecols) && ({1'b0, row_reg} < erows);
                end
                else if (op_reg == OP_VREAD)
                begin
                    c_addr = {RW'({1'b0, row_reg} - hrows), col_reg[CW-1:0]};
                    if (back_reg == '0)
                    begin
                        c_addr = {row_reg[RW-1:0], col_reg[CW-1:0]};
                    end
                end
            end
            S_PUT:
            begin
                c_we   = rdy && do_store;
                c_addr = {cline_reg[RW-1:0], bs_col[CW-1:0]};
                c_wd   = pval;
            end
            S_HRD:
            begin
                c_addr = {wt[RW-1:0], sc_reg[CW-1:0]};
            end
            S_HWR:
            begin
                h_we   = 1'b1;
                h_addr = {head_reg, sc_reg[CW-1:0]};
                c_addr = {wt[RW-1:0], sc_reg[CW-1:0]};
            end
            S_MRD:
            begin
                c_addr = {RW'(sr_reg + 7'd1), sc_reg[CW-1:0]};
            end
            S_MWR:
            begin
                c_we   = 1'b1;
                c_addr = {sr_reg[RW-1:0], sc_reg[CW-1:0]};
                c_wd   = c_rd;
            end
            S_BLK:
            begin
                c_we   = 1'b1;
                c_addr = {RW'(wb - 7'd1), sc_reg[CW-1:0]};
                c_wd   = BLANK_CELL;
            end
            default:
            begin
                c_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            cols_cfg_reg <= 8'd80;
            rows_cfg_reg <= 7'd48;
            ren_reg      <= 1'b0;
            rleft_reg    <= '0;
            rtop_reg     <= '0;
            rwid_reg     <= 8'd1;
            rhgt_reg     <= 7'd1;
            ccol_reg     <= '0;
            cline_reg    <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            back_reg     <= '0;
            tab_reg      <= '0;
            clr_req_reg  <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            clr_req_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLS:  cols_cfg_reg <= cfg_data;
                    REG_ROWS:  rows_cfg_reg <= cfg_data[6:0];
                    REG_REN:   ren_reg      <= cfg_data[0];
                    REG_LEFT:  rleft_reg    <= cfg_data[6:0];
                    REG_TOP:   rtop_reg     <= cfg_data[5:0];
                    REG_WIDTH: rwid_reg     <= cfg_data;
                    REG_HGT:   rhgt_reg     <= cfg_data[6:0];
                    default:   ren_reg      <= ren_reg;
                endcase
            end
            case (state_reg)
                S_CLR:
                begin
                    if (sw_stat.done)
                    begin
                        state_reg <= (op_reg == OP_CLEAR && out_valid == 1'b0
                                      && tab_reg == 3'd7) ? S_OUT : S_IDLE;
                        if (tab_reg == 3'd7)
                        begin
                            tab_reg   <= '0;
                            val_reg   <= '0;
                            out_valid <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= opcode;
                        ch_reg    <= char_code;
                        at_reg    <= attribute;
                        col_reg   <= cell_column;
                        row_reg   <= cell_row;
                        tab_reg   <= '0;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    val_reg   <= '0;
                    state_reg <= S_RES;
                    case (op_reg)
                        OP_PUT:
                        begin
                            state_reg <= rdy ? S_PUT : S_RES;
                        end
                        OP_READ, OP_VREAD:
                        begin
                            vblank_reg <= !(rdy && ({1'b0, col_reg} < ecols)
                                            && ({1'b0, row_reg} < erows));
                            vhist_reg  <= (op_reg == OP_VREAD) && (back_reg != '0)
                                          && ({1'b0, row_reg} < hrows);
                            state_reg  <= S_RDWAIT;
                        end
                        OP_CURS:
                        begin
                            if (rdy)
                            begin
                                ccol_reg <= ({1'b0, col_reg} < wl) ? wl :
                                    (({1'b0, col_reg} > wr - 8'd1) ? wr - 8'd1
                                                                   : {1'b0, col_reg});
                                cline_reg <= ({1'b0, row_reg} < wt) ? wt :
                                    (({1'b0, row_reg} > wb - 7'd1) ? wb - 7'd1
                                                                   : {1'b0, row_reg});
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (rdy)
                            begin
                                ccol_reg    <= '0;
                                cline_reg   <= '0;
                                head_reg    <= '0;
                                fill_reg    <= '0;
                                back_reg    <= '0;
                                ren_reg     <= 1'b0;
                                clr_req_reg <= 1'b1;
                                tab_reg     <= 3'd7;
                                state_reg   <= S_CLR;
                            end
                        end
                        OP_VUP:
                        begin
                            if (rdy && fill_reg != '0)
                            begin
                                back_reg <= (back_reg + VIEW_STEP > fill_reg) ? fill_reg
                                                                             : back_reg + VIEW_STEP;
                            end
                        end
                        OP_VDN:
                        begin
                            if (rdy && back_reg != '0)
                            begin
                                back_reg <= (back_reg <= VIEW_STEP) ? '0 : back_reg - VIEW_STEP;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_RES;
                        end
                    endcase
                    // view read from history starts its history port now
                end
                S_RDWAIT:
                begin
                    state_reg <= S_RES;
                    val_reg   <= vblank_reg ? BLANK_CELL : (vhist_reg ? h_rd : c_rd);
                end
                S_PUT:
                begin
                    ccol_reg <= pcol;
                    if (pline >= wb)
                    begin
                        cline_reg <= wb - 7'd1;
                        if (wb > wt + 7'd1)
                        begin
                            sc_reg    <= wl;
                            state_reg <= S_HRD;
                        end
                        else
                        begin
                            state_reg <= S_RES;
                        end
                    end
                    else
                    begin
                        cline_reg <= pline;
                        state_reg <= S_RES;
                    end
                    if (is_tab && !(pline >= wb && wb > wt + 7'd1))
                    begin
                        tab_reg <= tab_reg + 3'd1;
                        if (tab_reg != 3'd3)
                        begin
                            state_reg <= S_PUT;
                        end
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    if (sc_reg + 8'd1 >= wr)
                    begin
                        sc_reg    <= wl;
                        sr_reg    <= wt;
                        state_reg <= S_MRD;
                        if (wb == wt + 7'd1)
                        begin
                            state_reg <= S_BLK;
                        end
                    end
                    else
                    begin
                        sc_reg    <= sc_reg + 8'd1;
                        state_reg <= S_HRD;
                    end
                end
                S_MRD:
                begin
                    state_reg <= S_MWR;
                end
                S_MWR:
                begin
                    state_reg <= S_MRD;
                    if (sc_reg + 8'd1 >= wr)
                    begin
                        sc_reg <= wl;
                        sr_reg <= sr_reg + 7'd1;
                        if (sr_reg + 7'd2 >= wb)
                        begin
                            state_reg <= S_BLK;
                        end
                    end
                    else
                    begin
                        sc_reg <= sc_reg + 8'd1;
                    end
                end
                S_BLK:
                begin
                    if (sc_reg + 8'd1 >= wr)
                    begin
                        head_reg <= head_reg + 1'b1;
                        if (fill_reg < 9'(HISTORY_LINES))
                        begin
                            fill_reg <= fill_reg + 9'd1;
                        end
                        back_reg <= '0;
                        state_reg <= S_RES;
                        if (is_tab)
                        begin
                            tab_reg <= tab_reg + 3'd1;
                            if (tab_reg != 3'd3)
                            begin
                                state_reg <= S_PUT;
                            end
                        end
                    end
                    else
                    begin
                        sc_reg <= sc_reg + 8'd1;
                    end
                end
                S_RES:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign cell_value    = val_reg;
    assign cursor_column = ccol_reg[6:0];
    assign cursor_row    = cline_reg[5:0];
    assign view_offset   = back_reg;

`ifndef SYNTH
    // no request is taken during a clearing pass
    a_no_req_clr: assert property (@(posedge clk) disable iff (!rst_n)
        sw_stat.busy |-> !in_ready)
        else $error("request taken while clearing");
    // view offset never passes history fill
    a_back_fill: assert property (@(posedge clk) disable iff (!rst_n)
        back_reg <= fill_reg)
        else $error("view offset beyond history fill");
    // result is only shown in the output state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT))
        else $error("result valid outside output state");
`endif

endmodule

/* verif/text_console_cell_engine_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cell_engine_unit_test
// drives console requests through the valid/ready channels under random idling
// and stalls, predicts every response with an internal console model (cells,
// cursor, scrollback ring, view window) and compares it field by field
// ----------------------------------------------------------------------------
module text_console_cell_engine_unit_test;
    import tcce_pkg::*;

    localparam int NCOL       = DEF_MAX_COLUMNS;
    localparam int NROW       = DEF_MAX_ROWS;
    localparam int NHIST      = DEF_HISTORY_LINES;
    localparam int STUCK_LIMIT = 200000;

    // ------------------------------------------------------------------------
    // console model and store of expected responses
    // ------------------------------------------------------------------------
    class console_scoreboard;
        typedef struct {
            logic [15:0] value;
            logic [6:0]  ccol;
            logic [5:0]  crow;
            logic [8:0]  voff;
        } response_t;

        logic [15:0] cells [NROW*NCOL];
        logic [15:0] hist [NHIST*NCOL];
        int unsigned cols_reg, rows_reg, ren, left, top, wid, hgt;
        int unsigned cur_c, cur_r, head, fill, back;
        int unsigned wl, wr, wt, wb;
        response_t   awaited[$];
        int          errors;

        function new();
            cols_reg = 80; rows_reg = 48; ren = 0;
            left = 0; top = 0; wid = 1; hgt = 1;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            foreach (hist[i]) hist[i] = BLANK_CELL;
            cur_c = 0; cur_r = 0; head = 0; fill = 0; back = 0;
        endfunction

        function int unsigned ecols();
            return (cols_reg > NCOL) ? NCOL : cols_reg;
        endfunction

        function int unsigned erows();
            return (rows_reg > NROW) ? NROW : rows_reg;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                REG_COLS:  cols_reg = data;
                REG_ROWS:  rows_reg = data & 8'h7F;
                REG_REN:   ren = data & 8'h01;
                REG_LEFT:  left = data & 8'h7F;
                REG_TOP:   top = data & 8'h3F;
                REG_WIDTH: wid = data;
                REG_HGT:   hgt = data & 8'h7F;
                default: ;
            endcase
        endfunction

        function void find_window();
            int unsigned c, r, w, h;
            c = ecols(); r = erows();
            if (ren != 0 && left < c && top < r && wid != 0 && hgt != 0) begin
                w = (wid > c - left) ? c - left : wid;
                h = (hgt > r - top) ? r - top : hgt;
                wl = left; wr = left + w; wt = top; wb = top + h;
            end
            else begin
                wl = 0; wr = c; wt = 0; wb = r;
            end
        endfunction

        function void store(int unsigned c, int unsigned r, logic [15:0] v);
            if (c < ecols() && r < erows())
                cells[r*NCOL + c] = v;
        endfunction

        // shift the window up one row, old top row goes to the ring
        function void scroll_up();
            int unsigned line;
            line = head % NHIST;
            if (wb <= wt + 1) return;
            for (int unsigned c = wl; c < wr; c++)
                hist[line*NCOL + c] = cells[wt*NCOL + c];
            for (int unsigned r = wt; r + 1 < wb; r++)
                for (int unsigned c = wl; c < wr; c++)
                    cells[r*NCOL + c] = cells[(r+1)*NCOL + c];
            for (int unsigned c = wl; c < wr; c++)
                cells[(wb-1)*NCOL + c] = BLANK_CELL;
            head = (line + 1) % NHIST;
            if (fill < NHIST) fill++;
            back = 0;
        endfunction

        function void put_char(logic [7:0] ch);
            if (ch == CH_TAB) begin
                repeat (4) put_char(CH_SPACE);
                return;
            end
            if (ch == CH_NL) begin
                cur_c = wl;
                cur_r++;
            end
            else if (ch == CH_CR) begin
                cur_c = 0;
            end
            else if (ch == CH_BS) begin
                if (cur_c > 0) cur_c--;
                store(cur_c, cur_r, {PUT_ATTR, BLANK_CELL[7:0]});
            end
            else if (ch >= CH_SPACE && ch < CH_DEL) begin
                store(cur_c, cur_r, {PUT_ATTR, ch});
                cur_c++;
                if (cur_c >= wr) begin
                    cur_c = wl;
                    cur_r++;
                end
            end
            if (cur_r >= wb) begin
                scroll_up();
                cur_r = wb - 1;
            end
        endfunction

        function logic [15:0] view_read(int unsigned c, int unsigned r);
            int unsigned hrows, back_gap, idx;
            if (c >= ecols() || r >= erows()) return BLANK_CELL;
            if (back == 0) return cells[r*NCOL + c];
            hrows = (back < erows()) ? back : erows();
            if (r < hrows) begin
                back_gap = (back - r) % NHIST;
                idx = (head % NHIST + NHIST - back_gap) % NHIST;
                return hist[idx*NCOL + c];
            end
            return cells[(r - hrows)*NCOL + c];
        endfunction

        // an accepted request: update the model and queue its response
        function void note_request(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                                   logic [6:0] col, logic [5:0] row);
            response_t   rsp;
            bit          ok;
            int unsigned c, r;
            ok = (ecols() != 0 && erows() != 0);
            c = col; r = row;
            rsp.value = '0;
            find_window();
            case (opcode_t'(op))
                OP_PUT:   if (ok) put_char(ch);
                OP_WRITE: if (ok) store(c, r, {attr, ch});
                OP_READ:  rsp.value = (ok && c < ecols() && r < erows()) ?
                                      cells[r*NCOL + c] : BLANK_CELL;
                OP_CURS: begin
                    if (ok) begin
                        if (c < wl) c = wl;
                        if (r < wt) r = wt;
                        if (c > wr - 1) c = wr - 1;
                        if (r > wb - 1) r = wb - 1;
                        cur_c = c; cur_r = r;
                    end
                end
                OP_CLEAR: begin
                    if (ok) begin
                        wipe();
                        ren = 0;
                    end
                end
                OP_VUP: begin
                    if (ok && fill != 0)
                        back = (back + VIEW_STEP > fill) ? fill : back + VIEW_STEP;
                end
                OP_VDN: begin
                    if (ok && back != 0)
                        back = (back <= VIEW_STEP) ? 0 : back - VIEW_STEP;
                end
                default:  rsp.value = ok ? view_read(c, r) : BLANK_CELL;
            endcase
            rsp.ccol = cur_c[6:0];
            rsp.crow = cur_r[5:0];
            rsp.voff = back[8:0];
            awaited.push_back(rsp);
        endfunction

        function void check_response(logic [15:0] value, logic [6:0] ccol,
                                     logic [5:0] crow, logic [8:0] voff);
            response_t want;
            if (awaited.size() == 0) begin
                $error("response with no request outstanding: cell_value %h", value);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value) begin
                $error("cell_value expected %h actual %h", want.value, value);
                errors++;
            end
            if (ccol !== want.ccol) begin
                $error("cursor_column expected %0d actual %0d", want.ccol, ccol);
                errors++;
            end
            if (crow !== want.crow) begin
                $error("cursor_row expected %0d actual %0d", want.crow, crow);
                errors++;
            end
            if (voff !== want.voff) begin
                $error("view_offset expected %0d actual %0d", want.voff, voff);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [7:0]  char_code = '0;
    logic [7:0]  attribute = '0;
    logic [6:0]  cell_column = '0;
    logic [5:0]  cell_row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_row;
    logic [8:0]  view_offset;

    console_scoreboard sb = new();
    bit  sender_idles = 1'b1;
    bit  receiver_stalls = 1'b1;
    int  stuck_cycles = 0;

    text_console_cell_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .char_code(char_code), .attribute(attribute),
        .cell_column(cell_column), .cell_row(cell_row),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_value(cell_value), .cursor_column(cursor_column),
        .cursor_row(cursor_row), .view_offset(view_offset)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitors, response stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(opcode, char_code, attribute, cell_column, cell_row);
        if (rst_n && out_valid && out_ready)
            sb.check_response(cell_value, cursor_column, cursor_row, view_offset);
    end

    always @(posedge clk) begin
        out_ready <= !receiver_stalls || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("text_console_cell_engine_unit_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic send(opcode_t op, logic [7:0] ch, logic [7:0] attr,
                        logic [6:0] col, logic [5:0] row);
        while (sender_idles && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode      <= op;
        char_code   <= ch;
        attribute   <= attr;
        cell_column <= col;
        cell_row    <= row;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // hold off until every request has its response
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(logic [7:0] cols, logic [7:0] rows, logic [7:0] en,
                             logic [7:0] lft, logic [7:0] tp, logic [7:0] w,
                             logic [7:0] h);
        logic [7:0] vals [7];
        vals = '{cols, rows, en, lft, tp, w, h};
        drain();
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            sb.set_reg(i[2:0], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char(int nl_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < nl_pct) return CH_NL;
        sel = $urandom_range(0, 99);
        if (sel < 8)  return CH_CR;
        if (sel < 18) return CH_BS;
        if (sel < 26) return CH_TAB;
        if (sel < 85) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] pick_col();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 15));
    endfunction

    function automatic logic [5:0] pick_row();
        return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 7));
    endfunction

    task automatic random_request(int nl_pct);
        int      r;
        opcode_t op;
        r = $urandom_range(0, 999);
        if (r < 3)            op = OP_CLEAR;
        else if (r % 100 < 40) op = OP_PUT;
        else if (r % 100 < 52) op = OP_WRITE;
        else if (r % 100 < 62) op = OP_READ;
        else if (r % 100 < 70) op = OP_CURS;
        else if (r % 100 < 80) op = OP_VUP;
        else if (r % 100 < 86) op = OP_VDN;
        else                   op = OP_VREAD;
        send(op, (op == OP_PUT) ? pick_char(nl_pct) : 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), pick_col(), pick_row());
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] c, r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        // directed pass at the reset geometry
        configure(8'd80, 8'd48, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1);
        send(OP_WRITE, 8'hFF, 8'hFF, 7'd79, 6'd47);
        send(OP_WRITE, 8'h00, 8'h00, 7'd127, 6'd63);
        send(OP_READ,  8'h00, 8'h00, 7'd79, 6'd47);
        send(OP_READ,  8'h00, 8'h00, 7'd127, 6'd63);
        send(OP_VUP,   8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_CURS,  8'h00, 8'h00, 7'd127, 6'd63);
        send(OP_PUT,   8'd65, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_NL, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   8'd126, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_CR, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_BS, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_TAB, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_DEL, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   8'd0, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   8'd200, 8'h00, 7'd0, 6'd0);
        send(OP_VUP,   8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_VREAD, 8'h00, 8'h00, 7'd79, 6'd0);
        send(OP_VREAD, 8'h00, 8'h00, 7'd127, 6'd63);
        send(OP_VDN,   8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_VDN,   8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_CURS,  8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_PUT,   CH_BS, 8'h00, 7'd0, 6'd0);
        send(OP_CLEAR, 8'h00, 8'h00, 7'd0, 6'd0);
        send(OP_READ,  8'h00, 8'h00, 7'd79, 6'd46);

        // register extremes: largest values, smallest region, not ready
        configure(8'd255, 8'd127, 8'd1, 8'd127, 8'd63, 8'd255, 8'd127);
        repeat (25) random_request(10);
        configure(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 8'd1);
        repeat (40) random_request(20);
        configure(8'd0, 8'd5, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        repeat (20) random_request(20);
        configure(8'd128, 8'd64, 8'd0, 8'd3, 8'd2, 8'd5, 8'd0);
        repeat (20) random_request(3);

        // random geometries, mostly small so scrolls stay cheap
        for (int p = 0; p < 8; p++) begin
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 12));
            r = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 127))
                                            : 8'($urandom_range(1, 6));
            configure(c, r, 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                                  : 8'($urandom_range(0, c + 1)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 63))
                                                  : 8'($urandom_range(0, r + 1)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, c + 2)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                                  : 8'($urandom_range(0, r + 2)));
            sender_idles    = (p != 2);
            receiver_stalls = (p != 2);
            for (int i = 0; i < 50; i++) begin
                if (i == 25) drain();
                random_request((c > 16 || r > 8) ? 3 : 25);
            end
        end
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;

        // tiny screen: fill the scrollback ring and walk the view to its end
        configure(8'd2, 8'd2, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1);
        for (int i = 0; i < 330; i++)
            send(OP_PUT, ($urandom_range(0, 9) != 0) ? CH_NL : 8'($urandom_range(32, 126)),
                 8'h00, 7'd0, 6'd0);
        for (int i = 0; i < 120; i++) begin
            case ($urandom_range(0, 9))
                0:       send(OP_VDN, 8'h00, 8'h00, 7'd0, 6'd0);
                1, 2, 3: send(OP_VREAD, 8'h00, 8'h00, 7'($urandom_range(0, 2)),
                              6'($urandom_range(0, 2)));
                default: send(OP_VUP, 8'h00, 8'h00, 7'd0, 6'd0);
            endcase
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("text_console_cell_engine_unit_test: clean");
        else
            $display("text_console_cell_engine_unit_test: errors");
        $finish;
    end

endmodule
